>>> design/mpf_pkg.sv
package mpf_pkg;

  localparam int FRAC_BITS = 16;

  localparam int NUM_W = 96;
  localparam int DEN_W = 62;
  localparam int QUO_W = 41;
  localparam logic [QUO_W-1:0] M_CAP = {1'b1, {(QUO_W-1){1'b0}}};

  localparam int X_W = 43;
  localparam int XS_W = FRAC_BITS + 7;
  localparam int Y_W = XS_W + 32 - FRAC_BITS;
  localparam int N_W = Y_W - 30;
  localparam logic signed [X_W-1:0] X_HI = X_W'(32) << FRAC_BITS;
  localparam logic signed [X_W-1:0] X_LO = -(X_W'(64) << FRAC_BITS);

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [30:0] EXP_MAX = 31'h7fff_ffff;

  localparam int HORNER_TERMS = 9;
  localparam int HORNER_STAGES = 3 * HORNER_TERMS;
  localparam logic [32:0] RECIP [1:HORNER_TERMS] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824, 33'd858993459,
    33'd715827882, 33'd613566756, 33'd536870912, 33'd477218588
  };

  localparam int GN_W = 62;
  localparam int GD_W = 32;
  localparam int PROD_W = 94;

  typedef struct packed {
    logic signed [31:0] lhs_x;
    logic signed [31:0] lhs_y;
    logic signed [31:0] rhs_x;
    logic signed [31:0] rhs_y;
    logic [30:0]        scale_factor;
    logic [30:0]        rest_distance;
    logic [30:0]        spring_stiffness;
  } in_t;

  typedef struct packed {
    logic signed [31:0] delta_vx;
    logic signed [31:0] delta_vy;
    logic               coincident;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic        negx;
    logic        negy;
    logic        coin;
    logic [30:0] s;
    logic [30:0] k;
  } side_t;

endpackage

>>> design/mpf_geom.sv
module mpf_geom
  import mpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  in_t              in_data,
  output logic             out_valid,
  output side_t            out_side,
  output logic [NUM_W-1:0] out_num,
  output logic [DEN_W-1:0] out_den
);

  logic [32:0] dx, dy;
  side_t       side_in;
  logic [30:0] r_fix;

  logic        v1, v2, v3, v4;
  side_t       sd1, sd2, sd3, sd4;
  logic [30:0] r01;
  logic [DEN_W-1:0] den2, den3, den4;
  logic [63:0] sqx, sqy;
  logic [64:0] d2;
  logic [63:0] pl;
  logic [62:0] ph;

  always_comb begin
    dx = {in_data.lhs_x[31], in_data.lhs_x} - {in_data.rhs_x[31], in_data.rhs_x};
    dy = {in_data.lhs_y[31], in_data.lhs_y} - {in_data.rhs_y[31], in_data.rhs_y};
    side_in.ax = dx[32] ? 32'(-dx) : dx[31:0];
    side_in.ay = dy[32] ? 32'(-dy) : dy[31:0];
    side_in.negx = dx[32];
    side_in.negy = dy[32];
    side_in.coin = (dx == 33'd0) && (dy == 33'd0);
    side_in.s = (in_data.scale_factor == 31'd0) ? 31'd1 : in_data.scale_factor;
    side_in.k = in_data.spring_stiffness;
    r_fix = (in_data.rest_distance == 31'd0) ? 31'd1 : in_data.rest_distance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1 <= side_in;
      r01 <= r_fix;
      sd2 <= sd1;
      sqx <= sd1.ax * sd1.ax;
      sqy <= sd1.ay * sd1.ay;
      den2 <= r01 * r01;
      sd3 <= sd2;
      d2 <= 65'(sqx) + 65'(sqy);
      den3 <= den2;
      sd4 <= sd3;
      pl <= sd3.s * d2[32:0];
      ph <= sd3.s * d2[64:33];
      den4 <= den3;
      out_side <= sd4;
      out_num <= NUM_W'(pl) + (NUM_W'(ph) << 33);
      out_den <= den4;
    end
  end

endmodule

>>> design/mpf_qdiv.sv
module mpf_qdiv
  import mpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  side_t            in_side,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_valid,
  output side_t            out_side,
  output logic [QUO_W-1:0] out_m
);

  logic             vld [0:QUO_W];
  side_t            sd  [0:QUO_W];
  logic [DEN_W-1:0] rem [0:QUO_W];
  logic [DEN_W-1:0] dn  [0:QUO_W];
  logic [QUO_W-1:0] nq  [0:QUO_W];
  logic             cap [0:QUO_W];

  logic [DEN_W-1:0] hi_part;

  assign hi_part = DEN_W'(in_num[NUM_W-1:QUO_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= in_side;
      dn[0] <= in_den;
      rem[0] <= hi_part;
      nq[0] <= in_num[QUO_W-1:0];
      cap[0] <= hi_part >= in_den;
    end
  end

  genvar j;
  for (j = 1; j <= QUO_W; j++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {rem[j-1], nq[j-1][QUO_W-1]};
      ge = trial >= {1'b0, dn[j-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[j] <= sd[j-1];
        dn[j] <= dn[j-1];
        cap[j] <= cap[j-1];
        rem[j] <= ge ? DEN_W'(trial - {1'b0, dn[j-1]}) : trial[DEN_W-1:0];
        nq[j] <= {nq[j-1][QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= sd[QUO_W];
      out_m <= (cap[QUO_W] || nq[QUO_W] > M_CAP) ? M_CAP : nq[QUO_W];
    end
  end

endmodule

>>> design/mpf_exp.sv
module mpf_exp
  import mpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  side_t            in_side,
  input  logic [QUO_W-1:0] in_m,
  output logic             out_valid,
  output side_t            out_side,
  output logic [30:0]      out_u1,
  output logic [30:0]      out_u2,
  output logic             out_sat
);

  typedef struct packed {
    logic [29:0]    z;
    logic [31:0]    t;
    logic [31:0]    v;
    logic [31:0]    q;
    logic [N_W-1:0] n;
    logic           hi;
    logic           lo;
    logic           ov;
  } lane_t;

  logic signed [X_W-2:0] p;
  logic signed [X_W-1:0] x [0:1];

  logic                   va, vb, vc;
  side_t                  sda, sdb, sdc;
  logic signed [XS_W-1:0] xsa [0:1];
  logic                   hia [0:1];
  logic                   loa [0:1];
  logic signed [Y_W-1:0]  yb  [0:1];
  logic                   hib [0:1];
  logic                   lob [0:1];
  logic [N_W-1:0]         nc  [0:1];
  logic [29:0]            fc  [0:1];
  logic                   hic [0:1];
  logic                   loc [0:1];

  logic  hv [0:HORNER_STAGES];
  side_t hs [0:HORNER_STAGES];
  lane_t h  [0:HORNER_STAGES][0:1];

  logic [30:0] res [0:1];
  logic        lsat [0:1];

  always_comb begin
    p = $signed((X_W-1)'(in_side.s)) - $signed((X_W-1)'(in_m));
    x[0] = {p[X_W-2], p};
    x[1] = {p, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      hv[0] <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      hv[0] <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sda <= in_side;
      sdb <= sda;
      sdc <= sdb;
      hs[0] <= sdc;
    end
  end

  genvar k, l;
  for (l = 0; l < 2; l++) begin : g_front
    logic signed [XS_W+31:0] yp;
    logic [59:0]             zp;
    logic [N_W-1:0]          n_w;

    always_comb begin
      yp = xsa[l] * $signed({1'b0, LOG2E_Q30});
      zp = fc[l] * LN2_Q30;
      n_w = yb[l][Y_W-1:30];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xsa[l] <= x[l][XS_W-1:0];
        hia[l] <= x[l] >= X_HI;
        loa[l] <= x[l] <= X_LO;
        yb[l] <= yp[XS_W+31:FRAC_BITS];
        hib[l] <= hia[l];
        lob[l] <= loa[l];
        nc[l] <= n_w;
        fc[l] <= yb[l][29:0];
        hic[l] <= hib[l];
        loc[l] <= lob[l];
        h[0][l].z <= zp[59:30];
        h[0][l].t <= ONE_Q30;
        h[0][l].v <= '0;
        h[0][l].q <= '0;
        h[0][l].n <= nc[l];
        h[0][l].hi <= hic[l];
        h[0][l].lo <= loc[l];
        h[0][l].ov <= $signed(nc[l]) >= $signed(N_W'(31 - FRAC_BITS));
      end
    end
  end

  for (k = 0; k < HORNER_STAGES; k++) begin : g_horner
    localparam int DIV = HORNER_TERMS - k / 3;

    always_ff @(posedge clk) begin
      if (rst) begin
        hv[k+1] <= 1'b0;
      end else if (en) begin
        hv[k+1] <= hv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hs[k+1] <= hs[k];
      end
    end

    for (l = 0; l < 2; l++) begin : g_lane
      lane_t nxt;

      if (k % 3 == 0) begin : g_mul
        logic [61:0] prod;
        always_comb begin
          prod = h[k][l].z * h[k][l].t;
          nxt = h[k][l];
          nxt.v = prod[61:30];
        end
      end else if (k % 3 == 1) begin : g_recip
        logic [64:0] qp;
        always_comb begin
          qp = h[k][l].v * RECIP[DIV];
          nxt = h[k][l];
          nxt.q = qp[63:32];
        end
      end else begin : g_fix
        logic [31:0] qi;
        logic [31:0] r;
        logic [31:0] qc;
        always_comb begin
          qi = h[k][l].q * 32'(DIV);
          r = h[k][l].v - qi;
          qc = (r >= 32'(DIV)) ? h[k][l].q + 32'd1 : h[k][l].q;
          nxt = h[k][l];
          nxt.t = ONE_Q30 + qc;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          h[k+1][l] <= nxt;
        end
      end
    end
  end

  for (l = 0; l < 2; l++) begin : g_final
    logic signed [9:0] sh;
    logic [31:0]       shifted;
    lane_t             hf;

    always_comb begin
      hf = h[HORNER_STAGES][l];
      sh = $signed(10'(30 - FRAC_BITS)) - $signed({hf.n[N_W-1], hf.n});
      shifted = hf.t >> sh[4:0];
      lsat[l] = 1'b0;
      if (hf.lo) begin
        res[l] = '0;
      end else if (hf.hi || hf.ov) begin
        res[l] = EXP_MAX;
        lsat[l] = 1'b1;
      end else if (sh >= 10'sd32) begin
        res[l] = '0;
      end else if (shifted > 32'(EXP_MAX)) begin
        res[l] = EXP_MAX;
      end else begin
        res[l] = shifted[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= hv[HORNER_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= hs[HORNER_STAGES];
      out_u1 <= res[0];
      out_u2 <= res[1];
      out_sat <= lsat[0] | lsat[1];
    end
  end

endmodule

>>> design/mpf_scale.sv
module mpf_scale
  import mpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  side_t       in_side,
  input  logic [30:0] in_u1,
  input  logic [30:0] in_u2,
  input  logic        in_sat,
  output logic        out_valid,
  output out_t        out_data
);

  localparam int SW = PROD_W - FRAC_BITS;

  logic [31:0] g;

  logic        v1;
  side_t       sd1;
  logic [30:0] gm1;
  logic        gneg1;
  logic        sat1;

  logic            vld  [0:GN_W];
  side_t           sd   [0:GN_W];
  logic [GD_W-1:0] rem  [0:GN_W];
  logic [GD_W-1:0] dn   [0:GN_W];
  logic [GN_W-1:0] nq   [0:GN_W];
  logic            gneg [0:GN_W];
  logic            esat [0:GN_W];

  logic        v3, v4;
  side_t       sd3, sd4;
  logic        gneg3, gneg4, sat3, sat4;
  logic [62:0] pl [0:1];
  logic [62:0] ph [0:1];
  logic [PROD_W-1:0] pp [0:1];

  logic [31:0] lane_out [0:1];
  logic        lane_ovf [0:1];

  assign g = {1'b0, in_u2} - {1'b0, in_u1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      vld[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1 <= in_side;
      gneg1 <= g[31];
      gm1 <= g[31] ? 31'(-g) : g[30:0];
      sat1 <= in_sat;
      sd[0] <= sd1;
      gneg[0] <= gneg1;
      esat[0] <= sat1;
      nq[0] <= sd1.k * gm1;
      dn[0] <= {sd1.s, 1'b0};
      rem[0] <= '0;
    end
  end

  genvar j, l;
  for (j = 1; j <= GN_W; j++) begin : g_step
    logic [GD_W:0] trial;
    logic          ge;

    always_comb begin
      trial = {rem[j-1], nq[j-1][GN_W-1]};
      ge = trial >= {1'b0, dn[j-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[j] <= sd[j-1];
        dn[j] <= dn[j-1];
        gneg[j] <= gneg[j-1];
        esat[j] <= esat[j-1];
        rem[j] <= ge ? GD_W'(trial - {1'b0, dn[j-1]}) : trial[GD_W-1:0];
        nq[j] <= {nq[j-1][GN_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v3 <= vld[GN_W];
      v4 <= v3;
      out_valid <= v4;
    end
  end

  for (l = 0; l < 2; l++) begin : g_lane
    logic [31:0]   mag_d;
    logic          neg3;
    logic          neg4;
    logic [SW-1:0] sv;
    logic [31:0]   lim;
    logic [31:0]   mag;

    always_comb begin
      mag_d = (l == 0) ? sd[GN_W].ax : sd[GN_W].ay;
      neg4 = ((l == 0) ? sd4.negx : sd4.negy) ^ gneg4;
      neg3 = neg4;
      sv = pp[l][PROD_W-1:FRAC_BITS];
      lim = neg3 ? 32'h8000_0000 : 32'h7fff_ffff;
      lane_ovf[l] = sv > SW'(lim);
      mag = lane_ovf[l] ? lim : sv[31:0];
      lane_out[l] = neg3 ? 32'(-mag) : mag;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl[l] <= mag_d * nq[GN_W][30:0];
        ph[l] <= mag_d * nq[GN_W][GN_W-1:31];
        pp[l] <= PROD_W'(pl[l]) + (PROD_W'(ph[l]) << 31);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3 <= sd[GN_W];
      gneg3 <= gneg[GN_W];
      sat3 <= esat[GN_W];
      sd4 <= sd3;
      gneg4 <= gneg3;
      sat4 <= sat3;
      if (sd4.coin) begin
        out_data.delta_vx <= '0;
        out_data.delta_vy <= '0;
        out_data.coincident <= 1'b1;
        out_data.saturated <= 1'b0;
      end else begin
        out_data.delta_vx <= lane_out[0];
        out_data.delta_vy <= lane_out[1];
        out_data.coincident <= 1'b0;
        out_data.saturated <= sat4 | lane_ovf[0] | lane_ovf[1];
      end
    end
  end

endmodule

>>> design/morse_pair_force.sv
// Channel  Dir  Handshake              Payload
// pair     in   pair_valid/pair_ready  pair_data (in_t): two positions, s, r0, k
// dv       out  dv_valid/dv_ready      dv_data (out_t): velocity increment, flags
//
// One pair enters every cycle unless a stall on dv holds pair_ready low; results leave in pair order.
// Most of the pipeline lies in the two bit-per-stage dividers (41 and 62 stages) and the
// nine Horner terms of the exponential, three stages each.
// Reset clears every valid bit; the data registers are not reset.
// The whole pipeline advances whenever the output register is empty or taken,
// so a stall on dv holds every item in place.
module morse_pair_force
  import mpf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pair_valid,
  output logic pair_ready,
  input  in_t  pair_data,
  output logic dv_valid,
  input  logic dv_ready,
  output out_t dv_data
);

  logic en;

  logic             g_valid;
  side_t            g_side;
  logic [NUM_W-1:0] g_num;
  logic [DEN_W-1:0] g_den;

  logic             q_valid;
  side_t            q_side;
  logic [QUO_W-1:0] q_m;

  logic        e_valid;
  side_t       e_side;
  logic [30:0] e_u1, e_u2;
  logic        e_sat;

  assign en = !dv_valid || dv_ready;
  assign pair_ready = en;

  mpf_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pair_valid),
    .in_data   (pair_data),
    .out_valid (g_valid),
    .out_side  (g_side),
    .out_num   (g_num),
    .out_den   (g_den)
  );

  mpf_qdiv u_qdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .in_side   (g_side),
    .in_num    (g_num),
    .in_den    (g_den),
    .out_valid (q_valid),
    .out_side  (q_side),
    .out_m     (q_m)
  );

  mpf_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .in_side   (q_side),
    .in_m      (q_m),
    .out_valid (e_valid),
    .out_side  (e_side),
    .out_u1    (e_u1),
    .out_u2    (e_u2),
    .out_sat   (e_sat)
  );

  mpf_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_side   (e_side),
    .in_u1     (e_u1),
    .in_u2     (e_u2),
    .in_sat    (e_sat),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

endmodule

>>> tb/tb.sv
module tb
  import mpf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1250;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    in_t  pair;
    bit   typed;
    out_t res;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_ready;
  in_t  pair_data = '0;
  logic dv_valid;
  logic dv_ready = 1'b0;
  out_t dv_data;

  out_t increments_due[$];
  int   errors = 0;
  int   pairs_sent = 0;
  bit   free_run = 0;
  bit   held_once = 0;
  int   idle_cycles = 0;

  morse_pair_force dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready), .pair_data(pair_data),
    .dv_valid(dv_valid), .dv_ready(dv_ready), .dv_data(dv_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned morse_exp(longint x, inout bit sat);
    longint y30, n, f30, sh;
    longint unsigned z30, t;
    if (x >= (longint'(32) <<< FRAC_BITS)) begin
      sat = 1;
      return 64'h7fff_ffff;
    end
    if (x <= -(longint'(64) <<< FRAC_BITS)) return 0;
    y30 = (x * longint'(1549082005)) >>> FRAC_BITS;
    n = y30 >>> 30;
    f30 = y30 - (n <<< 30);
    if (n >= 31 - FRAC_BITS) begin
      sat = 1;
      return 64'h7fff_ffff;
    end
    z30 = (longint'(f30) * longint'(744261118)) >> 30;
    t = 64'd1 << 30;
    for (int i = 9; i >= 1; i--) t = (64'd1 << 30) + ((z30 * t) >> 30) / i;
    sh = 30 - FRAC_BITS - n;
    if (sh >= 63) return 0;
    t = t >> sh;
    return (t > 64'h7fff_ffff) ? 64'h7fff_ffff : t;
  endfunction

  function automatic logic [31:0] scale_increment(longint unsigned mag, longint unsigned wm,
                                                   bit neg, inout bit sat);
    logic [127:0] prod;
    logic [127:0] lim;
    prod = (128'(mag) * 128'(wm)) >> FRAC_BITS;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (prod > lim) begin
      sat = 1;
      prod = lim;
    end
    return neg ? -prod[31:0] : prod[31:0];
  endfunction

  function automatic out_t morse_increment(in_t pr);
    longint dx, dy, p, g;
    longint unsigned s, r0, k, ax, ay, u, u2, gm, wm, m;
    logic [127:0] num, quo;
    bit sat;
    out_t r;
    sat = 0;
    r = '0;
    dx = longint'($signed(pr.lhs_x)) - longint'($signed(pr.rhs_x));
    dy = longint'($signed(pr.lhs_y)) - longint'($signed(pr.rhs_y));
    s = (pr.scale_factor == 0) ? 1 : pr.scale_factor;
    r0 = (pr.rest_distance == 0) ? 1 : pr.rest_distance;
    k = pr.spring_stiffness;
    if (dx == 0 && dy == 0) begin
      r.coincident = 1'b1;
      return r;
    end
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    num = 128'(s) * (128'(ax * ax) + 128'(ay * ay));
    quo = num / (128'(r0) * 128'(r0));
    if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
    m = quo[63:0];
    p = longint'(s) - longint'(m);
    u = morse_exp(p, sat);
    u2 = morse_exp(2 * p, sat);
    g = longint'(u2) - longint'(u);
    gm = (g < 0) ? -g : g;
    wm = (k * gm) / (2 * s);
    r.delta_vx = scale_increment(ax, wm, (dx < 0) != (g < 0), sat);
    r.delta_vy = scale_increment(ay, wm, (dy < 0) != (g < 0), sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic in_t random_pair();
    in_t pr;
    int unsigned r0;
    pr.lhs_x = $urandom;
    pr.lhs_y = $urandom;
    pr.rhs_x = $urandom;
    pr.rhs_y = $urandom;
    pr.scale_factor = 31'($urandom);
    pr.rest_distance = 31'($urandom);
    pr.spring_stiffness = 31'($urandom);
    if ($urandom_range(0, 99) < 75) begin
      // Cells near their rest distance, each axis offset within twice r0.
      r0 = $urandom_range(1 << 12, 24 << 16);
      pr.rest_distance = 31'(r0);
      pr.rhs_x = pr.lhs_x + $signed($urandom_range(0, 4 * r0)) - $signed(2 * r0);
      pr.rhs_y = pr.lhs_y + $signed($urandom_range(0, 4 * r0)) - $signed(2 * r0);
      pr.scale_factor = 31'($urandom_range(1 << 12, 10 << 16));
      if ($urandom_range(0, 3) == 0) pr.spring_stiffness = 31'($urandom_range(0, 32 << 16));
    end else if ($urandom_range(0, 19) == 0) begin
      pr.rhs_x = pr.lhs_x;
      pr.rhs_y = pr.lhs_y;
    end
    return pr;
  endfunction

  function automatic pair_row_t row(int lx, int ly, int rx, int ry, int s, int r0, int k,
                                    bit typed, out_t res);
    pair_row_t w;
    w.pair.lhs_x = lx;
    w.pair.lhs_y = ly;
    w.pair.rhs_x = rx;
    w.pair.rhs_y = ry;
    w.pair.scale_factor = 31'(s);
    w.pair.rest_distance = 31'(r0);
    w.pair.spring_stiffness = 31'(k);
    w.typed = typed;
    w.res = res;
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic offer_pair(in_t pr, bit typed, out_t res);
    int gap;
    out_t due;
    pair_valid <= 1'b1;
    pair_data <= pr;
    @(posedge clk);
    while (!pair_ready) @(posedge clk);
    due = typed ? res : morse_increment(pr);
    increments_due = {increments_due, due};
    pairs_sent++;
    gap = 0;
    if (!free_run && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      pair_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int stall_left;
    out_t want;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (dv_valid && dv_ready) begin
        if (increments_due.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = increments_due.pop_front();
          if (dv_data.delta_vx !== want.delta_vx)
            report_mismatch("delta_vx", dv_data.delta_vx, want.delta_vx);
          if (dv_data.delta_vy !== want.delta_vy)
            report_mismatch("delta_vy", dv_data.delta_vy, want.delta_vy);
          if (dv_data.coincident !== want.coincident)
            report_mismatch("coincident", dv_data.coincident, want.coincident);
          if (dv_data.saturated !== want.saturated)
            report_mismatch("saturated", dv_data.saturated, want.saturated);
        end
      end
      if (!held_once && pairs_sent >= 400) begin
        held_once = 1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !free_run && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        dv_ready <= 1'b0;
      end else begin
        dv_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((pair_valid && pair_ready) || (dv_valid && dv_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pair_row_t rows[$];
    out_t zero;
    out_t coin;
    zero = '0;
    coin = '0;
    coin.coincident = 1'b1;
    rows = {rows, row(0, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 1, coin)};
    rows = {rows, row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, coin)};
    rows = {rows, row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                      0, 0, 0, 1, coin)};
    rows = {rows, row(32'h7fffffff, 0, 32'h80000000, 0, 1 << 16, 1 << 16, 0, 1, zero)};
    rows = {rows, row(5 << 16, 0, 0, 0, 2 << 16, 5 << 16, 32'h7fffffff, 1, zero)};
    rows = {rows, row(0, 3 << 16, 0, 0, 3 << 16, 3 << 16, 32'h7fffffff, 1, zero)};
    rows = {rows, row(1, 0, 0, 0, 8 << 16, 32'h7fffffff, 32'h7fffffff, 0, zero)};
    rows = {rows, row(1, 1, 0, 0, 0, 0, 1 << 16, 0, zero)};
    rows = {rows, row(0, 0, 1, 0, 0, 1 << 16, 32'h7fffffff, 0, zero)};
    rows = {rows, row(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, zero)};
    rows = {rows, row(1 << 16, -(1 << 16), 0, 0, 1 << 16, 2 << 16, 4 << 16, 0, zero)};
    rows = {rows, row(-(3 << 16), 2 << 16, 0, 0, 1 << 16, 2 << 16, 4 << 16, 0, zero)};
    rows = {rows, row(1 << 15, 0, 0, 0, 31 << 16, 1 << 16, 1 << 16, 0, zero)};
    rows = {rows, row(0, 0, 40 << 16, 0, 1 << 16, 1 << 16, 32'h7fffffff, 0, zero)};
    rows = {rows, row(100, -100, -100, 100, 1, 1, 1, 0, zero)};
    rows = {rows, row(7 << 16, 7 << 16, 2 << 16, 2 << 16, 1 << 15, 6 << 16, 9 << 16, 0,
                      zero)};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) offer_pair(rows[i].pair, rows[i].typed, rows[i].res);
    pair_valid <= 1'b0;
    while (increments_due.size() != 0) @(posedge clk);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      free_run = (i >= 700 && i < 850);
      offer_pair(random_pair(), 0, zero);
    end
    free_run = 0;
    pair_valid <= 1'b0;
    while (increments_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
design/mpf_pkg.sv
design/mpf_geom.sv
design/mpf_qdiv.sv
design/mpf_exp.sv
design/mpf_scale.sv
design/morse_pair_force.sv
tb/tb.sv
